// ----- sv/box_to_label_mask_raster_macros.svh -----
// Assertion macros used by the mask rasterizer checker.
`ifndef BOX_TO_LABEL_MASK_RASTER_MACROS_SVH
`define BOX_TO_LABEL_MASK_RASTER_MACROS_SVH

// Same-cycle implication, off during reset.
`define BLMR_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mask rasterizer check failed");

// Next-cycle implication, off during reset.
`define BLMR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mask rasterizer check failed");

// Next-cycle implication that also watches reset itself.
`define BLMR_ASSERT_NEXT_ALWAYS(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("mask rasterizer check failed");

`endif

// ----- sv/bblmr_pkg.sv -----
// Types, constants and helpers of the box-to-label mask rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package bblmr_pkg;

  // Frame and coordinate geometry
  localparam int MAX_WIDTH       = 64;
  localparam int MAX_HEIGHT      = 64;
  localparam int MAX_CLASSES     = 32;
  localparam int COORD_FRAC_BITS = 16;

  localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COORD_W = COORD_FRAC_BITS + 1;
  localparam int AREA_W  = 2 * COORD_FRAC_BITS + 1;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int X_W     = $clog2(MAX_WIDTH + 1);
  localparam int Y_W     = $clog2(MAX_HEIGHT + 1);
  localparam int NC_W    = $clog2(MAX_CLASSES + 1);

  // Fixed field widths of the ports
  localparam int DIM_W     = 7;
  localparam int CLS_W     = 6;
  localparam int LABEL_W   = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int RXY_W     = 6;
  localparam int CH_W      = 5;
  localparam int PIX_W     = 8;

  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << COORD_FRAC_BITS;

  // Corner-to-index and area products, one per cycle
  localparam int SETUP_STEPS = 5;
  localparam int STEP_W      = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_DIFF  = 3'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_DIFFICULT  = 3'd1,
    STAT_FRAME      = 3'd2,
    STAT_BACKGROUND = 3'd3,
    STAT_CHANNEL    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_PREP,
    ST_DRAW,
    ST_READ,
    ST_READ_DATA,
    ST_RESULT
  } state_t;

  // One pixel of the mask store
  typedef struct packed {
    logic [LABEL_W-1:0]     label;
    logic [AREA_W-1:0]      area;
    logic [MAX_CLASSES-1:0] bits;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_CLEAR = '{label: '0, area: '1, bits: MAX_CLASSES'(1)};

  // Row-major pixel address
  function automatic logic [ADDR_W-1:0] addr_of(input logic [Y_W-1:0] y,
                                                input logic [X_W-1:0] x);
    addr_of = ADDR_W'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

endpackage

`default_nettype wire

// ----- sv/bblmr_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bblmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/box_to_label_mask_raster.sv -----
// Top level of the box-to-label mask rasterizer.
// Usage:
//   Input channel (in_valid/in_stall) carries one command word: clear frame,
//   draw box or read pixel. Every command gives exactly one result word on
//   the output channel (out_valid/out_stall): status and pixel_value.
//   Registers are written through cfg_write/cfg_index/cfg_data; the user
//   must write them only while idle, as the block does not enforce it.
// Steps, from the accepted command to the loaded result:
//   clear - check, sweep of all 4096 entries, result.
//   draw  - check, 5 multiply steps, 1 bound step, one pixel per cycle,
//           drain, result; a flagged or inverted box goes from check
//           to result, one covering no pixel from the bound step to result.
//   read  - check, one registered memory read, result.
// Throughput: one command in flight; the next is taken as soon as the
//   previous result is placed in the output register.
// Reset: the block sweeps all 4096 mask entries back to their clear value,
//   one per cycle, holding in_stall high; no result word is produced.
// Stall: a waiting result holds in the output register; a second finished
//   result waits inside the block until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module box_to_label_mask_raster (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [bblmr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bblmr_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [bblmr_pkg::CMD_W-1:0]     cmd,
  input  wire logic [bblmr_pkg::COORD_W-1:0]   box_left,
  input  wire logic [bblmr_pkg::COORD_W-1:0]   box_top,
  input  wire logic [bblmr_pkg::COORD_W-1:0]   box_right,
  input  wire logic [bblmr_pkg::COORD_W-1:0]   box_bottom,
  input  wire logic [bblmr_pkg::LABEL_W-1:0]   box_label,
  input  wire logic                            box_difficult,
  input  wire logic [bblmr_pkg::RXY_W-1:0]     read_x,
  input  wire logic [bblmr_pkg::RXY_W-1:0]     read_y,
  input  wire logic [bblmr_pkg::CH_W-1:0]      read_channel,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [bblmr_pkg::STATUS_W-1:0]  status,
  output logic      [bblmr_pkg::PIX_W-1:0]     pixel_value
);

  import bblmr_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic               multi_channel_mode;
  logic [CLS_W-1:0]   class_count;
  logic [LABEL_W-1:0] background_label;
  logic               accept_difficult;

  // Saturated configuration
  logic [X_W-1:0]  w_sat;
  logic [Y_W-1:0]  h_sat;
  logic [NC_W-1:0] nc_sat;

  // Sequencer
  state_t state, state_next;

  // Captured command word
  cmd_t               cur_cmd;
  logic [COORD_W-1:0] l_q, t_q, r_q, b_q;
  logic [LABEL_W-1:0] lab_q;
  logic               diff_q;
  logic [RXY_W-1:0]   rx_q, ry_q;
  logic [CH_W-1:0]    rch_q;

  // Box geometry
  logic [STEP_W-1:0]  step;
  logic [COORD_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [AREA_W-1:0]  area;
  logic [X_W-1:0]     x0, x1, xe, xe_next, cx;
  logic [Y_W-1:0]     y0, y1, ye, ye_next, cy;

  // Pixel walk
  logic              issue_done;
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;

  // Clearing sweep
  logic [ADDR_W-1:0] sweep_addr;
  logic              sweep_reply;
  logic              sweep_last;

  // Result staging
  status_t          res_status;
  logic [PIX_W-1:0] res_pixel;
  logic             load_out;

  // Memory port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  entry_t            ram_rdata;
  logic [ENTRY_W-1:0] ram_rword;

  assign ram_rdata = entry_t'(ram_rword);

  bblmr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ENTRY_W'(ram_wdata)),
    .raddr (ram_raddr),
    .rdata (ram_rword)
  );

  // Clamp the frame size and class count to their usable ranges
  always_comb begin
    if (frame_width == '0) begin
      w_sat = X_W'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_sat = X_W'(MAX_WIDTH);
    end else begin
      w_sat = X_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_sat = Y_W'(1);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h_sat = Y_W'(MAX_HEIGHT);
    end else begin
      h_sat = Y_W'(frame_height);
    end
    if (class_count == '0) begin
      nc_sat = NC_W'(1);
    end else if (int'(class_count) > MAX_CLASSES) begin
      nc_sat = NC_W'(MAX_CLASSES);
    end else begin
      nc_sat = NC_W'(class_count);
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width        <= DIM_W'(64);
      frame_height       <= DIM_W'(64);
      multi_channel_mode <= 1'b0;
      class_count        <= CLS_W'(32);
      background_label   <= '0;
      accept_difficult   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width        <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height       <= cfg_data[DIM_W-1:0];
        CFG_MULTI_MODE:   multi_channel_mode <= cfg_data[0];
        CFG_CLASS_COUNT:  class_count        <= cfg_data[CLS_W-1:0];
        CFG_BACKGROUND:   background_label   <= cfg_data[LABEL_W-1:0];
        CFG_ACCEPT_DIFF:  accept_difficult   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Share one multiplier across the area and the four corner indexes
  always_comb begin
    case (step)
      STEP_W'(0): begin
        mul_a = r_q - l_q;
        mul_b = b_q - t_q;
      end
      STEP_W'(1): begin
        mul_a = COORD_W'(w_sat);
        mul_b = l_q;
      end
      STEP_W'(2): begin
        mul_a = COORD_W'(w_sat);
        mul_b = r_q;
      end
      STEP_W'(3): begin
        mul_a = COORD_W'(h_sat);
        mul_b = t_q;
      end
      STEP_W'(4): begin
        mul_a = COORD_W'(h_sat);
        mul_b = b_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Clip the walk to the frame
  assign xe_next    = (x1 < w_sat) ? x1 : w_sat;
  assign ye_next    = (y1 < h_sat) ? y1 : h_sat;
  assign sweep_last = (sweep_addr == ADDR_W'(CELLS - 1));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory controls and handshake
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    load_out   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pend_addr;
    ram_wdata  = ram_rdata;
    ram_raddr  = addr_of(cy, cx);
    unique case (state)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = ENTRY_CLEAR;
        if (sweep_last) begin
          state_next = sweep_reply ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        unique case (cur_cmd)
          CMD_CLEAR: state_next = ST_SWEEP;
          CMD_READ:  state_next = ST_READ;
          CMD_DRAW: begin
            if (lab_q == background_label ||
                (diff_q && !accept_difficult) ||
                (multi_channel_mode && lab_q >= LABEL_W'(nc_sat)) ||
                l_q > COORD_ONE || t_q > COORD_ONE ||
                r_q > COORD_ONE || b_q > COORD_ONE ||
                r_q < l_q || b_q < t_q) begin
              state_next = ST_RESULT;
            end else begin
              state_next = ST_SETUP;
            end
          end
          default: state_next = ST_RESULT;
        endcase
      end
      ST_SETUP: begin
        if (step == STEP_W'(SETUP_STEPS - 1)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (x0 >= xe_next || y0 >= ye_next) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW: begin
        // Read the next pixel while the previous one is written back
        ram_we = pend_valid && (multi_channel_mode || area < ram_rdata.area);
        if (multi_channel_mode) begin
          ram_wdata.bits = (ram_rdata.bits & ~MAX_CLASSES'(1)) |
                           (MAX_CLASSES'(1) << lab_q);
        end else begin
          ram_wdata.label = lab_q;
          ram_wdata.area  = area;
        end
        if (issue_done && !pend_valid) begin
          state_next = ST_RESULT;
        end
      end
      ST_READ: begin
        ram_raddr  = addr_of(Y_W'(ry_q), X_W'(rx_q));
        state_next = ST_READ_DATA;
      end
      ST_READ_DATA: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        load_out = !out_valid || !out_stall;
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sweep counter and the reply flag of a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
    end else if (state == ST_SWEEP) begin
      sweep_addr <= sweep_last ? '0 : sweep_addr + ADDR_W'(1);
    end else if (state == ST_CHECK) begin
      sweep_reply <= 1'b1;
    end
  end

  // Walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= '0;
      issue_done <= 1'b1;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        ST_CHECK: step <= '0;
        ST_SETUP: step <= step + STEP_W'(1);
        ST_PREP: begin
          issue_done <= 1'b0;
          pend_valid <= 1'b0;
        end
        ST_DRAW: begin
          pend_valid <= !issue_done;
          if (!issue_done && cx + X_W'(1) == xe && cy + Y_W'(1) == ye) begin
            issue_done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Capture the word, compute geometry and build the result
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_cmd    <= cmd_t'(cmd);
        l_q        <= box_left;
        t_q        <= box_top;
        r_q        <= box_right;
        b_q        <= box_bottom;
        lab_q      <= box_label;
        diff_q     <= box_difficult;
        rx_q       <= read_x;
        ry_q       <= read_y;
        rch_q      <= read_channel;
        res_status <= STAT_OK;
        res_pixel  <= '0;
      end
      ST_CHECK: begin
        // Flag order: background, difficult, channel, outside frame
        if (cur_cmd == CMD_DRAW) begin
          if (lab_q == background_label) begin
            res_status <= STAT_BACKGROUND;
          end else if (diff_q && !accept_difficult) begin
            res_status <= STAT_DIFFICULT;
          end else if (multi_channel_mode && lab_q >= LABEL_W'(nc_sat)) begin
            res_status <= STAT_CHANNEL;
          end else if (l_q > COORD_ONE || t_q > COORD_ONE ||
                       r_q > COORD_ONE || b_q > COORD_ONE) begin
            res_status <= STAT_FRAME;
          end
        end
      end
      ST_SETUP: begin
        case (step)
          STEP_W'(0): area <= prod[AREA_W-1:0];
          STEP_W'(1): x0   <= prod[COORD_FRAC_BITS +: X_W];
          STEP_W'(2): x1   <= prod[COORD_FRAC_BITS +: X_W];
          STEP_W'(3): y0   <= prod[COORD_FRAC_BITS +: Y_W];
          STEP_W'(4): y1   <= prod[COORD_FRAC_BITS +: Y_W];
          default: ;
        endcase
      end
      ST_PREP: begin
        xe <= xe_next;
        ye <= ye_next;
        cx <= x0;
        cy <= y0;
      end
      ST_DRAW: begin
        pend_addr <= ram_raddr;
        if (!issue_done) begin
          if (cx + X_W'(1) == xe) begin
            cx <= x0;
            cy <= cy + Y_W'(1);
          end else begin
            cx <= cx + X_W'(1);
          end
        end
      end
      ST_READ_DATA: begin
        if (X_W'(rx_q) >= w_sat || Y_W'(ry_q) >= h_sat) begin
          res_status <= STAT_FRAME;
        end else if (multi_channel_mode) begin
          if (NC_W'(rch_q) >= nc_sat) begin
            res_status <= STAT_CHANNEL;
          end else begin
            res_pixel <= PIX_W'((ram_rdata.bits >> rch_q) & MAX_CLASSES'(1));
          end
        end else begin
          res_pixel <= ram_rdata.label;
        end
      end
      default: ;
    endcase
  end

  // Output register: load a finished result, drop a taken word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid   <= 1'b1;
      status      <= res_status;
      pixel_value <= res_pixel;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bblmr_checker.sv -----
// Port-level checks of the mask rasterizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "box_to_label_mask_raster_macros.svh"

module bblmr_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [bblmr_pkg::STATUS_W-1:0] status,
  input wire logic [bblmr_pkg::PIX_W-1:0]    pixel_value
);

  import bblmr_pkg::*;

  // A stalled result word holds
  `BLMR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({status, pixel_value}))

  // Reset starts the clearing sweep, which refuses input
  `BLMR_ASSERT_NEXT_ALWAYS(a_reset_sweep, rst, in_stall)

  // One command in flight: an accepted word closes the input
  `BLMR_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // Status codes stay within the defined set
  `BLMR_ASSERT_NOW(a_status_code, out_valid, status <= STAT_CHANNEL)

  // A refused command returns no pixel data
  `BLMR_ASSERT_NOW(a_refused_zero, out_valid && status != STAT_OK, pixel_value == '0)

endmodule

bind box_to_label_mask_raster bblmr_checker u_checker (.*);

`default_nettype wire
